// ===== sv/tcl_pkg.sv =====
package tcl_pkg;

  localparam int LINE_BYTES        = 32;
  localparam int TRANSMITTER_COUNT = 4;
  localparam int ADDR_W            = $clog2(LINE_BYTES);
  localparam int POS_W             = ADDR_W + 1;
  localparam int HDR_BYTES         = 5;
  localparam int MAG_W             = 33;
  localparam int OUT_W             = 48;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEL_LIMIT = 8'h34;

  typedef enum logic [3:0] {
    CMD_UP      = 4'd0,
    CMD_DOWN    = 4'd1,
    CMD_SPEED   = 4'd2,
    CMD_QUERY   = 4'd3,
    CMD_KDD     = 4'd4,
    CMD_KUD     = 4'd5,
    CMD_SELECT  = 4'd6,
    CMD_REVERSE = 4'd7,
    CMD_MODE    = 4'd8,
    CMD_RESET   = 4'd9,
    CMD_NONE    = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HRD,
    ST_HUSE,
    ST_DEC,
    ST_NRD,
    ST_NUSE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       clear;
    logic       set_neg;
    logic       add;
    logic [3:0] digit;
  } num_ctl_t;

  typedef struct packed {
    logic             neg;
    logic             any;
    logic [MAG_W-1:0] mag;
  } num_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

// ===== sv/tcl_ram.sv =====
module tcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/tcl_num.sv =====
module tcl_num (
  input  logic              clk,
  input  tcl_pkg::num_ctl_t ctl,
  output tcl_pkg::num_t     num
);
  import tcl_pkg::*;

  localparam logic [MAG_W+3:0] SAT_LIM = (MAG_W+4)'(33'h080000000);
  localparam logic [MAG_W-1:0] SAT_VAL = 33'h080000001;

  num_t             num_r;
  logic [MAG_W+3:0] prod;

  assign prod = {1'b0, num_r.mag, 3'b000} + {3'b000, num_r.mag, 1'b0}
              + {{(MAG_W){1'b0}}, ctl.digit};

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      num_r <= '0;
    end else if (ctl.set_neg) begin
      num_r.neg <= 1'b1;
    end else if (ctl.add) begin
      num_r.any <= 1'b1;
      num_r.mag <= (prod > SAT_LIM) ? SAT_VAL : prod[MAG_W-1:0];
    end
  end

  assign num = num_r;

endmodule

// ===== sv/text_command_line_decoder.sv =====
// Channel | Ports                          | Item
// in      | in_tvalid in_tready in_tdata   | rx_byte
// out     | out_tvalid out_tready out_tdata| command transmitter value paddle_mode
//
// Bytes are taken while idle. A CR LF ending a line starts the decode: the line
// head is read byte by byte and then decoded, then the number parser scans the
// line byte by byte through the line store's single read port; the result is
// loaded from ST_OUT, where it waits only while an earlier result stalls.
// in_tready is low during the decode. Reset clears the write position and the
// CR flag; the line store is not cleared. A waiting result holds out_tdata.
module text_command_line_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [3:0] command, [5:4] transmitter,
                                  // [37:6] value, [40:38] paddle_mode, rest zero
);
  import tcl_pkg::*;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] wp_r, wp_nxt, wp_adv;
  logic              cr_r, cr_nxt;
  logic [ADDR_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              num2_r, num2_nxt, dig_r, dig_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [1:0]        xm_r, xm_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [7:0]        hdr_r [HDR_BYTES];
  logic [7:0]        hdr_nxt [HDR_BYTES];
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_rdata, cur;
  num_ctl_t          nctl;
  num_t              num;
  logic              xm_ok;
  logic [31:0]       num_val;

  tcl_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_tdata),
    .rdata(ram_rdata)
  );

  tcl_num u_num (
    .clk(clk),
    .ctl(nctl),
    .num(num)
  );

  assign cur    = (pos_r < {1'b0, len_r}) ? ram_rdata : 8'd0;
  assign wp_adv = (wp_r == ADDR_W'(LINE_BYTES - 1)) ? wp_r : wp_r + 1'b1;
  assign xm_ok  = num.any && ((num.mag == '0) ||
                  (!num.neg && num.mag < MAG_W'(TRANSMITTER_COUNT)));
  assign num_val = num.neg
    ? ((num.mag >= MAG_W'(33'h080000000)) ? 32'h80000000 : 32'd0 - num.mag[31:0])
    : ((num.mag > MAG_W'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : num.mag[31:0]);

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cr_nxt        = cr_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    num2_nxt      = num2_r;
    dig_nxt       = dig_r;
    cmd_nxt       = cmd_r;
    xm_nxt        = xm_r;
    mode_nxt      = mode_r;
    val_nxt       = val_r;
    hdr_nxt       = hdr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    nctl          = '0;
    ram_we        = 1'b0;
    ram_addr      = pos_r[ADDR_W-1:0];
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ram_addr  = wp_r;
        if (in_tvalid) begin
          ram_we = 1'b1;
          wp_nxt = wp_adv;
          cr_nxt = (in_tdata == CH_CR);
          if (cr_r && in_tdata == CH_LF) begin
            len_nxt   = wp_adv;
            wp_nxt    = '0;
            pos_nxt   = '0;
            state_nxt = ST_HRD;
          end
        end
      end
      ST_HRD: begin
        state_nxt = ST_HUSE;
      end
      ST_HUSE: begin
        for (int i = 0; i < HDR_BYTES; i++) begin
          if (pos_r == POS_W'(i)) begin
            hdr_nxt[i] = cur;
          end
        end
        if (pos_r == POS_W'(HDR_BYTES - 1)) begin
          state_nxt = ST_DEC;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ST_HRD;
        end
      end
      ST_DEC: begin
        cmd_nxt   = CMD_NONE;
        xm_nxt    = '0;
        val_nxt   = '0;
        mode_nxt  = '0;
        state_nxt = ST_OUT;
        nctl.clear = 1'b1;
        num2_nxt  = 1'b0;
        dig_nxt   = 1'b0;
        if (hdr_r[1] == ":" && (hdr_r[0] == "u" || hdr_r[0] == "d" ||
                                hdr_r[0] == "s" || hdr_r[0] == "c")) begin
          cmd_nxt   = (hdr_r[0] == "u") ? CMD_UP : (hdr_r[0] == "d") ? CMD_DOWN :
                      (hdr_r[0] == "s") ? CMD_SPEED : CMD_QUERY;
          pos_nxt   = POS_W'(2);
          state_nxt = ST_NRD;
        end else if (hdr_r[0] == "k" && hdr_r[1] == "d" && hdr_r[2] == "d" &&
                     hdr_r[3] == ":") begin
          cmd_nxt   = CMD_KDD;
          pos_nxt   = POS_W'(4);
          state_nxt = ST_NRD;
        end else if (hdr_r[0] == "k" && hdr_r[1] == "u" && hdr_r[2] == "d" &&
                     hdr_r[3] == ":") begin
          cmd_nxt   = CMD_KUD;
          pos_nxt   = POS_W'(4);
          state_nxt = ST_NRD;
        end else if (hdr_r[0] == "r" && hdr_r[1] == "e" && hdr_r[2] == "s" &&
                     hdr_r[3] == "e" && hdr_r[4] == "t") begin
          cmd_nxt = CMD_RESET;
        end else if (hdr_r[0] == "t" && hdr_r[1] == ":") begin
          if (hdr_r[2] >= "0" && hdr_r[2] < CH_SEL_LIMIT) begin
            cmd_nxt = CMD_SELECT;
            xm_nxt  = hdr_r[2][1:0];
          end
        end else if (hdr_r[0] == "p" && hdr_r[1] == "r") begin
          cmd_nxt = CMD_REVERSE;
        end else if (hdr_r[0] == "p" && hdr_r[1] == "m" && hdr_r[2] == ":") begin
          cmd_nxt = CMD_MODE;
          case (hdr_r[3])
            "a":     mode_nxt = 3'd0;
            "b":     mode_nxt = 3'd1;
            "s":     mode_nxt = 3'd2;
            "m":     mode_nxt = 3'd3;
            "u":     mode_nxt = 3'd4;
            default: cmd_nxt  = CMD_NONE;
          endcase
        end
      end
      ST_NRD: begin
        state_nxt = ST_NUSE;
      end
      ST_NUSE: begin
        state_nxt = ST_NRD;
        if (!dig_r && is_blank(cur)) begin
          pos_nxt = pos_r + 1'b1;
        end else if (!dig_r && (cur == "+" || cur == "-")) begin
          nctl.set_neg = (cur == "-");
          dig_nxt      = 1'b1;
          pos_nxt      = pos_r + 1'b1;
        end else if (is_digit(cur)) begin
          nctl.add   = 1'b1;
          nctl.digit = cur[3:0];
          dig_nxt    = 1'b1;
          pos_nxt    = pos_r + 1'b1;
        end else if (num2_r) begin
          val_nxt   = num_val;
          state_nxt = ST_OUT;
        end else if (!xm_ok) begin
          cmd_nxt   = CMD_NONE;
          state_nxt = ST_OUT;
        end else begin
          xm_nxt = num.mag[1:0];
          if (cmd_r == CMD_QUERY) begin
            state_nxt = ST_OUT;
          end else begin
            nctl.clear = 1'b1;
            num2_nxt   = 1'b1;
            dig_nxt    = 1'b0;
            pos_nxt    = pos_r + 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, mode_r, val_r, xm_r, cmd_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      cr_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cr_r        <= cr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    pos_r      <= pos_nxt;
    num2_r     <= num2_nxt;
    dig_r      <= dig_nxt;
    cmd_r      <= cmd_nxt;
    xm_r       <= xm_nxt;
    mode_r     <= mode_nxt;
    val_r      <= val_nxt;
    hdr_r      <= hdr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/tcl_checker.sv =====
module tcl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  import tcl_pkg::*;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= CMD_NONE)
    else $error("command code out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] != CMD_MODE |-> out_tdata[40:38] == 3'd0)
    else $error("paddle mode set on non-mode command");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:0] == CMD_QUERY || out_tdata[3:0] >= CMD_SELECT)
    |-> out_tdata[37:6] == 32'd0)
    else $error("value set on command without argument");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] >= CMD_REVERSE |-> out_tdata[5:4] == 2'd0)
    else $error("transmitter set on command without one");

endmodule

bind text_command_line_decoder tcl_checker u_tcl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
